// ===== rtl/m4inv_pkg.sv =====
package m4inv_pkg;

  // Element format
  localparam int EW = 32;
  localparam int FB = 16;

  // Exact widths of the intermediate terms
  localparam int MINOR_W = 2 * EW + 1;
  localparam int ACC_W   = 2 * MINOR_W + 3;
  localparam int QB      = EW + 1;
  localparam int DIV_W_A = ACC_W + QB + 1;
  localparam int DIV_W_B = ACC_W + 2 * FB;
  localparam int DIV_W   = (DIV_W_A > DIV_W_B) ? DIV_W_A : DIV_W_B;
  localparam int DSTEP_W = $clog2(QB + 2);

  localparam logic [DSTEP_W-1:0] DSTEP_INIT = DSTEP_W'(QB + 1);
  localparam logic [QB-1:0] LIM_POS = {{(QB - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {{(QB - EW){1'b0}}, 1'b1, {(EW - 1){1'b0}}};

  // Operand store: elements, then the upper minors, then the lower minors
  localparam int OPND_DEPTH = 28;
  localparam int OPND_AW    = 5;
  localparam int S_BASE     = 16;
  localparam int C_BASE     = 22;

  localparam logic [4:0] SETUP_LAST = 5'(29);
  localparam logic [1:0] TERM_LAST  = 2'(2);
  localparam logic [3:0] IDX_LAST   = 4'(15);

  localparam int PAIR_A [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_B [6] = '{1, 2, 3, 2, 3, 3};
  localparam int COF_ROW [4] = '{1, 0, 3, 2};
  localparam int COF_MINOR [4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_SET_RD, ST_SET_MUL, ST_SET_WAIT, ST_DET_CHK,
    ST_COF_RD, ST_COF_MUL, ST_COF_WAIT, ST_DIV_START, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {DST_NONE, DST_MINOR, DST_DET} dest_t;

  typedef struct packed {
    logic [OPND_AW-1:0] a_sel;
    logic [OPND_AW-1:0] b_sel;
    logic               neg;
    logic               clear;
    dest_t              dest;
    logic [OPND_AW-1:0] dest_addr;
  } mac_op_t;

  typedef struct packed {
    logic               load_we;
    logic [3:0]         load_addr;
    logic               rd_en;
    mac_op_t            op;
    logic               mul_start;
    logic               minor_we;
    logic               det_we;
    logic               div_start;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic det_zero;
  } stat_t;

  // Minors and determinant: one product term per index
  function automatic mac_op_t setup_op(input logic [4:0] idx);
    mac_op_t op;
    int p, k, t, a, b, hi, base, m;
    p = int'(idx);
    op = '0;
    t = p & 1;
    if (p < 24) begin
      if (p < 12) begin
        k = p >> 1;
        hi = 0;
        base = S_BASE;
      end else begin
        k = (p - 12) >> 1;
        hi = 8;
        base = C_BASE;
      end
      a = PAIR_A[k];
      b = PAIR_B[k];
      if (t == 0) begin
        op.a_sel = OPND_AW'(hi + a);
        op.b_sel = OPND_AW'(hi + 4 + b);
        op.clear = 1'b1;
      end else begin
        op.a_sel = OPND_AW'(hi + 4 + a);
        op.b_sel = OPND_AW'(hi + b);
        op.neg = 1'b1;
        op.dest = DST_MINOR;
        op.dest_addr = OPND_AW'(base + k);
      end
    end else begin
      m = p - 24;
      op.a_sel = OPND_AW'(S_BASE + m);
      op.b_sel = OPND_AW'(C_BASE + 5 - m);
      op.neg = (m == 1) || (m == 4);
      op.clear = (m == 0);
      op.dest = (m == 5) ? DST_DET : DST_NONE;
    end
    return op;
  endfunction

  // Cofactor of output position oidx, term t of three
  function automatic mac_op_t cof_op(input logic [3:0] oidx, input logic [1:0] term);
    mac_op_t op;
    int i, j, t, col, row;
    i = int'(oidx[3:2]);
    j = int'(oidx[1:0]);
    t = int'(term);
    op = '0;
    row = COF_ROW[j];
    col = (t < i) ? t : t + 1;
    op.a_sel = OPND_AW'(row * 4 + col);
    op.b_sel = OPND_AW'(((j < 2) ? C_BASE : S_BASE) + COF_MINOR[i][t]);
    op.neg = (t == 1) ^ (((i + j) & 1) == 1);
    op.clear = (t == 0);
    op.dest = DST_NONE;
    return op;
  endfunction

endpackage

// ===== rtl/m4inv_ctrl.sv =====
module m4inv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             last,
  output m4inv_pkg::cmd_t  cmd,
  input  m4inv_pkg::stat_t stat
);

  m4inv_pkg::state_t state, state_next;
  logic [3:0] load_count;
  logic [4:0] sidx;
  logic [1:0] term;
  logic [3:0] oidx;
  logic in_acc, out_acc;
  logic setup_phase;
  m4inv_pkg::mac_op_t op;

  assign in_acc  = item_valid && !item_stall;
  assign out_acc = result_valid && !result_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      m4inv_pkg::ST_LOAD: begin
        if (in_acc && load_count == m4inv_pkg::IDX_LAST) state_next = m4inv_pkg::ST_SET_RD;
      end
      m4inv_pkg::ST_SET_RD:  state_next = m4inv_pkg::ST_SET_MUL;
      m4inv_pkg::ST_SET_MUL: state_next = m4inv_pkg::ST_SET_WAIT;
      m4inv_pkg::ST_SET_WAIT: begin
        if (!stat.mul_busy) begin
          state_next = (sidx == m4inv_pkg::SETUP_LAST) ? m4inv_pkg::ST_DET_CHK
                                                       : m4inv_pkg::ST_SET_RD;
        end
      end
      m4inv_pkg::ST_DET_CHK: begin
        state_next = stat.det_zero ? m4inv_pkg::ST_OUT : m4inv_pkg::ST_COF_RD;
      end
      m4inv_pkg::ST_COF_RD:  state_next = m4inv_pkg::ST_COF_MUL;
      m4inv_pkg::ST_COF_MUL: state_next = m4inv_pkg::ST_COF_WAIT;
      m4inv_pkg::ST_COF_WAIT: begin
        if (!stat.mul_busy) begin
          state_next = (term == m4inv_pkg::TERM_LAST) ? m4inv_pkg::ST_DIV_START
                                                      : m4inv_pkg::ST_COF_RD;
        end
      end
      m4inv_pkg::ST_DIV_START: state_next = m4inv_pkg::ST_DIV_WAIT;
      m4inv_pkg::ST_DIV_WAIT: begin
        if (!stat.div_busy) state_next = m4inv_pkg::ST_OUT;
      end
      m4inv_pkg::ST_OUT: begin
        if (out_acc) begin
          if (oidx == m4inv_pkg::IDX_LAST) state_next = m4inv_pkg::ST_LOAD;
          else if (stat.det_zero) state_next = m4inv_pkg::ST_OUT;
          else state_next = m4inv_pkg::ST_COF_RD;
        end
      end
      default: state_next = m4inv_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    setup_phase = (state == m4inv_pkg::ST_SET_RD) || (state == m4inv_pkg::ST_SET_MUL) ||
                  (state == m4inv_pkg::ST_SET_WAIT);
    op = setup_phase ? m4inv_pkg::setup_op(sidx) : m4inv_pkg::cof_op(oidx, term);
    item_stall   = (state != m4inv_pkg::ST_LOAD);
    result_valid = (state == m4inv_pkg::ST_OUT);
    last         = (oidx == m4inv_pkg::IDX_LAST);
    cmd = '0;
    cmd.op        = op;
    cmd.load_we   = in_acc;
    cmd.load_addr = load_count;
    cmd.rd_en     = (state == m4inv_pkg::ST_SET_RD) || (state == m4inv_pkg::ST_COF_RD);
    cmd.mul_start = (state == m4inv_pkg::ST_SET_MUL) || (state == m4inv_pkg::ST_COF_MUL);
    cmd.minor_we  = (state == m4inv_pkg::ST_SET_WAIT) && !stat.mul_busy &&
                    (op.dest == m4inv_pkg::DST_MINOR);
    cmd.det_we    = (state == m4inv_pkg::ST_SET_WAIT) && !stat.mul_busy &&
                    (op.dest == m4inv_pkg::DST_DET);
    cmd.div_start = (state == m4inv_pkg::ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4inv_pkg::ST_LOAD;
      load_count <= '0;
      sidx <= '0;
      term <= '0;
      oidx <= '0;
    end else begin
      state <= state_next;
      if (in_acc) load_count <= load_count + 4'd1;
      if (state == m4inv_pkg::ST_SET_WAIT && !stat.mul_busy) begin
        sidx <= (sidx == m4inv_pkg::SETUP_LAST) ? 5'd0 : sidx + 5'd1;
      end
      if (state == m4inv_pkg::ST_COF_WAIT && !stat.mul_busy) begin
        term <= (term == m4inv_pkg::TERM_LAST) ? 2'd0 : term + 2'd1;
      end
      if (out_acc) oidx <= oidx + 4'd1;
    end
  end

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    in_acc && load_count == m4inv_pkg::IDX_LAST |=> state == m4inv_pkg::ST_SET_RD)
    else $error("sixteenth element did not start the computation");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    out_acc && oidx == m4inv_pkg::IDX_LAST |=> state == m4inv_pkg::ST_LOAD && load_count == 4'd0)
    else $error("last result did not return to loading");

  a_no_cof_singular: assert property (@(posedge clk) disable iff (rst)
    state == m4inv_pkg::ST_COF_RD |-> !stat.det_zero)
    else $error("cofactor work on a singular matrix");

endmodule

// ===== rtl/m4inv_dpath.sv =====
module m4inv_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [m4inv_pkg::EW-1:0]      element,
  input  m4inv_pkg::cmd_t               cmd,
  output m4inv_pkg::stat_t              stat,
  output logic [m4inv_pkg::EW-1:0]      inverse_element,
  output logic                          singular,
  output logic                          overflow
);

  // Operand store: two registered read ports, one write port
  logic [m4inv_pkg::MINOR_W-1:0] opnd_mem [m4inv_pkg::OPND_DEPTH];
  logic [m4inv_pkg::MINOR_W-1:0] rd_a, rd_b;
  logic                          mem_we;
  logic [m4inv_pkg::OPND_AW-1:0] mem_waddr;
  logic [m4inv_pkg::MINOR_W-1:0] mem_wdata;

  // Shift-add multiply-accumulate
  logic [m4inv_pkg::ACC_W-1:0]   acc, mcand;
  logic [m4inv_pkg::MINOR_W-1:0] mplier, mag_a, mag_b;
  logic                          msign;
  logic [m4inv_pkg::ACC_W-1:0]   det, abs_acc, abs_det;

  // Restoring divider
  logic [m4inv_pkg::DIV_W-1:0]   rem, dsh;
  logic [m4inv_pkg::QB-1:0]      q, lim, mag_q, sval;
  logic [m4inv_pkg::DSTEP_W-1:0] dstep;
  logic                          high, qneg, ge, ovf;

  assign mem_we    = cmd.load_we || cmd.minor_we;
  assign mem_waddr = cmd.load_we ? {1'b0, cmd.load_addr} : cmd.op.dest_addr;
  assign mem_wdata = cmd.load_we ?
    {{(m4inv_pkg::MINOR_W - m4inv_pkg::EW){element[m4inv_pkg::EW-1]}}, element} :
    acc[m4inv_pkg::MINOR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) opnd_mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) begin
      rd_a <= opnd_mem[cmd.op.a_sel];
      rd_b <= opnd_mem[cmd.op.b_sel];
    end
  end

  assign mag_a = rd_a[m4inv_pkg::MINOR_W-1] ? -rd_a : rd_a;
  assign mag_b = rd_b[m4inv_pkg::MINOR_W-1] ? -rd_b : rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (cmd.mul_start) begin
      mplier <= mag_b;
    end else if (mplier != '0) begin
      mplier <= mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mcand <= {{(m4inv_pkg::ACC_W - m4inv_pkg::MINOR_W){1'b0}}, mag_a};
      msign <= rd_a[m4inv_pkg::MINOR_W-1] ^ rd_b[m4inv_pkg::MINOR_W-1] ^ cmd.op.neg;
      if (cmd.op.clear) acc <= '0;
    end else if (mplier != '0) begin
      if (mplier[0]) begin
        acc <= acc + (mcand ^ {m4inv_pkg::ACC_W{msign}}) +
               {{(m4inv_pkg::ACC_W - 1){1'b0}}, msign};
      end
      mcand <= mcand << 1;
    end
    if (cmd.det_we) det <= acc;
  end

  assign abs_acc = acc[m4inv_pkg::ACC_W-1] ? -acc : acc;
  assign abs_det = det[m4inv_pkg::ACC_W-1] ? -det : det;
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      dstep <= '0;
    end else if (cmd.div_start) begin
      dstep <= m4inv_pkg::DSTEP_INIT;
    end else if (dstep != '0) begin
      dstep <= dstep - m4inv_pkg::DSTEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= {{(m4inv_pkg::DIV_W - m4inv_pkg::ACC_W){1'b0}}, abs_acc} << (2 * m4inv_pkg::FB);
      dsh  <= {{(m4inv_pkg::DIV_W - m4inv_pkg::ACC_W){1'b0}}, abs_det} << m4inv_pkg::QB;
      q    <= '0;
      high <= 1'b0;
      qneg <= acc[m4inv_pkg::ACC_W-1] ^ det[m4inv_pkg::ACC_W-1];
    end else if (dstep != '0) begin
      if (dstep == m4inv_pkg::DSTEP_INIT) begin
        high <= ge;
      end else begin
        if (ge) rem <= rem - dsh;
        q <= {q[m4inv_pkg::QB-2:0], ge};
      end
      dsh <= dsh >> 1;
    end
  end

  // Saturate, then restore the sign
  always_comb begin
    lim   = qneg ? m4inv_pkg::LIM_NEG : m4inv_pkg::LIM_POS;
    ovf   = high || (q > lim);
    mag_q = ovf ? lim : q;
    sval  = qneg ? -mag_q : mag_q;
    singular        = stat.det_zero;
    overflow        = !stat.det_zero && ovf;
    inverse_element = stat.det_zero ? '0 : sval[m4inv_pkg::EW-1:0];
  end

  assign stat.mul_busy = (mplier != '0);
  assign stat.div_busy = (dstep != '0);
  assign stat.det_zero = (det == '0);

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !stat.mul_busy && !stat.div_busy)
    else $error("multiply started while a unit was busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.mul_busy && !stat.div_busy)
    else $error("divide started while a unit was busy");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

endmodule

// ===== rtl/matrix4_inverse.sv =====
// 4x4 matrix inverse by cofactors; one element per input transaction, row by row.
// Load: one element per cycle, sixteen transactions; input stalls from the sixteenth
// until the sixteenth result transaction is taken. Compute: each product is one
// shift-add pass that ends once the bits of the second operand are used up; a matrix
// completes far sooner when it is singular.
// Reset (rst, synchronous) returns to loading; the element store is undefined until written.
module matrix4_inverse (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [m4inv_pkg::EW-1:0] element,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [m4inv_pkg::EW-1:0] inverse_element,
  output logic                     singular,
  output logic                     overflow,
  output logic                     last
);

  // Command and status between the sequencer and the arithmetic
  m4inv_pkg::cmd_t  cmd;
  m4inv_pkg::stat_t stat;

  // Sequencer: loading, minor and determinant schedule, cofactor terms,
  // division hand-off and result handshake
  m4inv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .last         (last),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Arithmetic: operand store, shared multiply-accumulate, divider,
  // saturation; result fields hold steady while a result transaction waits
  m4inv_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .element         (element),
    .cmd             (cmd),
    .stat            (stat),
    .inverse_element (inverse_element),
    .singular        (singular),
    .overflow        (overflow)
  );

endmodule
